// File: sv/quaternion_attitude_propagator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the attitude propagator
// Same-cycle and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ATTITUDE_PROPAGATOR_ASSERT_SVH
`define QUATERNION_ATTITUDE_PROPAGATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QAP_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("attitude propagator check failed");

// Consequent must hold in the cycle after the antecedent.
`define QAP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("attitude propagator check failed");

`endif

// File: sv/qap_pkg.sv
// ----------------------------------------------------------------------------
// qap_pkg
// Types, opcodes and constant tables shared by the attitude propagator.
// ----------------------------------------------------------------------------
package qap_pkg;

  localparam logic signed [31:0] Q_ONE    = 32'sh4000_0000;
  localparam logic [31:0]        TS_RESET = 32'd42949673;
  localparam logic [63:0]        SQRT_BIT0 = 64'h4000_0000_0000_0000;

  // datapath operations
  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_CAPTURE   = 5'd1;
  localparam logic [4:0] OP_TERM_MUL  = 5'd2;
  localparam logic [4:0] OP_TERM_ACC  = 5'd3;
  localparam logic [4:0] OP_SCL_HI    = 5'd4;
  localparam logic [4:0] OP_SCL_LO    = 5'd5;
  localparam logic [4:0] OP_SCL_ADD   = 5'd6;
  localparam logic [4:0] OP_SCL_SUM   = 5'd7;
  localparam logic [4:0] OP_SQ_MUL    = 5'd8;
  localparam logic [4:0] OP_SQ_ACC    = 5'd9;
  localparam logic [4:0] OP_IDENT     = 5'd10;
  localparam logic [4:0] OP_SQRT_INIT = 5'd11;
  localparam logic [4:0] OP_SQRT_STEP = 5'd12;
  localparam logic [4:0] OP_DIV_INIT  = 5'd13;
  localparam logic [4:0] OP_DIV_STEP  = 5'd14;
  localparam logic [4:0] OP_DIV_WRITE = 5'd15;
  localparam logic [4:0] OP_OUT       = 5'd16;

  // product terms of q (x) (0, omega), three per component w, x, y, z
  localparam logic [1:0] TERM_QSEL [12] = '{2'd1, 2'd2, 2'd3,
                                            2'd0, 2'd2, 2'd3,
                                            2'd0, 2'd1, 2'd3,
                                            2'd0, 2'd1, 2'd2};
  localparam logic [1:0] TERM_OSEL [12] = '{2'd0, 2'd1, 2'd2,
                                            2'd0, 2'd2, 2'd1,
                                            2'd1, 2'd2, 2'd0,
                                            2'd2, 2'd1, 2'd0};
  localparam logic       TERM_NEG  [12] = '{1'b1, 1'b1, 1'b1,
                                            1'b0, 1'b0, 1'b1,
                                            1'b0, 1'b1, 1'b0,
                                            1'b0, 1'b0, 1'b1};

  typedef struct packed {
    logic [4:0] op;
    logic [3:0] term;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic norm_zero;
    logic out_free;
  } stat_t;

endpackage

// File: sv/qap_if.sv
// ----------------------------------------------------------------------------
// qap channel interfaces
// Request (load or propagate) and response (attitude) channels.
// ----------------------------------------------------------------------------
interface qap_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] load_w;
  logic signed [31:0] load_x;
  logic signed [31:0] load_y;
  logic signed [31:0] load_z;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;

  modport source (output valid, command, load_w, load_x, load_y, load_z,
                  rate_x, rate_y, rate_z, input ready);
  modport sink (input valid, command, load_w, load_x, load_y, load_z,
                rate_x, rate_y, rate_z, output ready);
endinterface

interface qap_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] att_w;
  logic signed [31:0] att_x;
  logic signed [31:0] att_y;
  logic signed [31:0] att_z;
  logic               identity_fallback;

  modport source (output valid, att_w, att_x, att_y, att_z, identity_fallback,
                  input ready);
  modport sink (input valid, att_w, att_x, att_y, att_z, identity_fallback,
                output ready);
endinterface

// File: sv/qap_datapath.sv
// ----------------------------------------------------------------------------
// qap_datapath
// Attitude state, shared multipliers, square root and divider steps.
// ----------------------------------------------------------------------------
module qap_datapath (
  input  logic               clk,
  input  logic               rst,
  input  qap_pkg::cmd_t      cmd,
  output qap_pkg::stat_t     stat,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic signed [31:0] load_w,
  input  logic signed [31:0] load_x,
  input  logic signed [31:0] load_y,
  input  logic signed [31:0] load_z,
  input  logic signed [31:0] rate_x,
  input  logic signed [31:0] rate_y,
  input  logic signed [31:0] rate_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] att_w,
  output logic signed [31:0] att_x,
  output logic signed [31:0] att_y,
  output logic signed [31:0] att_z,
  output logic               fallback
);

  logic signed [31:0] q [4];
  logic signed [31:0] c [4];
  logic signed [31:0] om [3];
  logic [31:0]        ts;
  logic signed [63:0] prod;
  logic signed [41:0] racc;
  logic signed [59:0] sp;
  logic signed [59:0] sl;
  logic [64:0]        nsum;
  logic [63:0]        sn;
  logic [63:0]        sres;
  logic [63:0]        sbit;
  logic [31:0]        rem;
  logic [30:0]        dsh;
  logic [30:0]        quo;
  logic               fb;

  logic [1:0]         qsel;
  logic [1:0]         osel;
  logic               tneg;
  logic [31:0]        cu;
  logic [31:0]        mag;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [41:0] term_ext;
  logic [15:0]        half;
  logic signed [59:0] sc_p;
  logic signed [59:0] inc;
  logic signed [43:0] upd;
  logic signed [31:0] upd_sat;
  logic [63:0]        nsat;
  logic [63:0]        st;
  logic               sge;
  logic [32:0]        dt;
  logic               dge;
  logic [31:0]        qv;

  always_comb begin
    qsel     = qap_pkg::TERM_QSEL[cmd.term];
    osel     = qap_pkg::TERM_OSEL[cmd.term];
    tneg     = qap_pkg::TERM_NEG[cmd.term];
    cu       = c[cmd.idx];
    mag      = cu[31] ? (~cu + 32'd1) : cu;
    if (cmd.op == qap_pkg::OP_SQ_MUL) begin
      mul_a = {1'b0, mag};
      mul_b = {1'b0, mag};
    end else begin
      mul_a = {q[qsel][31], q[qsel]};
      mul_b = {om[osel][31], om[osel]};
    end
    mul_p    = mul_a * mul_b;
    term_ext = 42'(prod >>> 24);
    half     = (cmd.op == qap_pkg::OP_SCL_HI) ? ts[31:16] : ts[15:0];
    sc_p     = racc * $signed({1'b0, half});
    inc      = sp >>> 17;
    upd      = 44'(q[cmd.idx]) + 44'(inc);
    if (upd > 44'sd2147483647) begin
      upd_sat = 32'sh7fff_ffff;
    end else if (upd < -44'sd2147483648) begin
      upd_sat = 32'sh8000_0000;
    end else begin
      upd_sat = upd[31:0];
    end
    nsat     = nsum[64] ? '1 : nsum[63:0];
    st       = sres + sbit;
    sge      = (sn >= st);
    dt       = {rem, dsh[30]};
    dge      = (dt >= {1'b0, sres[31:0]});
    qv       = {1'b0, quo};
    stat.norm_zero = (nsum == 65'd0);
    stat.out_free  = !out_valid || out_ready;
  end

  // state, configuration and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      q[0]      <= qap_pkg::Q_ONE;
      q[1]      <= '0;
      q[2]      <= '0;
      q[3]      <= '0;
      ts        <= qap_pkg::TS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        ts <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == qap_pkg::OP_IDENT) begin
        q[0] <= qap_pkg::Q_ONE;
        q[1] <= '0;
        q[2] <= '0;
        q[3] <= '0;
      end
      if (cmd.op == qap_pkg::OP_DIV_WRITE) begin
        q[cmd.idx] <= cu[31] ? (~qv + 32'd1) : qv;
      end
      if (cmd.op == qap_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      qap_pkg::OP_CAPTURE: begin
        c[0]  <= load_w;
        c[1]  <= load_x;
        c[2]  <= load_y;
        c[3]  <= load_z;
        om[0] <= rate_x;
        om[1] <= rate_y;
        om[2] <= rate_z;
        racc  <= '0;
        nsum  <= '0;
        fb    <= 1'b0;
      end
      qap_pkg::OP_TERM_MUL, qap_pkg::OP_SQ_MUL: begin
        prod <= mul_p[63:0];
      end
      qap_pkg::OP_TERM_ACC: begin
        racc <= tneg ? (racc - term_ext) : (racc + term_ext);
      end
      qap_pkg::OP_SCL_HI: begin
        sp <= sc_p;
      end
      qap_pkg::OP_SCL_LO: begin
        sl <= sc_p;
      end
      qap_pkg::OP_SCL_ADD: begin
        sp <= sp + (sl >>> 16);
      end
      qap_pkg::OP_SCL_SUM: begin
        c[cmd.idx] <= upd_sat;
        racc       <= '0;
      end
      qap_pkg::OP_SQ_ACC: begin
        nsum <= nsum + {1'b0, prod};
      end
      qap_pkg::OP_IDENT: begin
        fb <= 1'b1;
      end
      qap_pkg::OP_SQRT_INIT: begin
        sn   <= nsat;
        sres <= '0;
        sbit <= qap_pkg::SQRT_BIT0;
      end
      qap_pkg::OP_SQRT_STEP: begin
        if (sge) begin
          sn   <= sn - st;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      qap_pkg::OP_DIV_INIT: begin
        rem <= {1'b0, mag[31:1]};
        dsh <= {mag[0], 30'd0};
        quo <= '0;
      end
      qap_pkg::OP_DIV_STEP: begin
        rem <= dge ? 32'(dt - {1'b0, sres[31:0]}) : dt[31:0];
        dsh <= dsh << 1;
        quo <= {quo[29:0], dge};
      end
      qap_pkg::OP_OUT: begin
        att_w    <= q[0];
        att_x    <= q[1];
        att_y    <= q[2];
        att_z    <= q[3];
        fallback <= fb;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/qap_ctrl.sv
// ----------------------------------------------------------------------------
// qap_ctrl
// Sequencer that steps the datapath through update and renormalization.
// ----------------------------------------------------------------------------
module qap_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           command,
  output logic           in_ready,
  output qap_pkg::cmd_t  cmd,
  input  qap_pkg::stat_t stat
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TMUL  = 4'd1;
  localparam logic [3:0] S_TACC  = 4'd2;
  localparam logic [3:0] S_SHI   = 4'd3;
  localparam logic [3:0] S_SLO   = 4'd4;
  localparam logic [3:0] S_SADD  = 4'd5;
  localparam logic [3:0] S_SSUM  = 4'd6;
  localparam logic [3:0] S_SQMUL = 4'd7;
  localparam logic [3:0] S_SQACC = 4'd8;
  localparam logic [3:0] S_CHK   = 4'd9;
  localparam logic [3:0] S_SQS   = 4'd10;
  localparam logic [3:0] S_DVI   = 4'd11;
  localparam logic [3:0] S_DVS   = 4'd12;
  localparam logic [3:0] S_DVW   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0] state, state_next;
  logic [3:0] k, k_next;
  logic [1:0] i, i_next;
  logic [4:0] it, it_next;

  always_comb begin
    state_next = state;
    k_next     = k;
    i_next     = i;
    it_next    = it;
    cmd.op     = qap_pkg::OP_NONE;
    cmd.term   = k;
    cmd.idx    = i;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op     = qap_pkg::OP_CAPTURE;
          state_next = command ? S_TMUL : S_SQMUL;
          k_next     = '0;
          i_next     = '0;
        end
      end
      S_TMUL: begin
        cmd.op     = qap_pkg::OP_TERM_MUL;
        state_next = S_TACC;
      end
      S_TACC: begin
        cmd.op     = qap_pkg::OP_TERM_ACC;
        k_next     = k + 4'd1;
        state_next = (k == (4'(i) * 4'd3 + 4'd2)) ? S_SHI : S_TMUL;
      end
      S_SHI: begin
        cmd.op     = qap_pkg::OP_SCL_HI;
        state_next = S_SLO;
      end
      S_SLO: begin
        cmd.op     = qap_pkg::OP_SCL_LO;
        state_next = S_SADD;
      end
      S_SADD: begin
        cmd.op     = qap_pkg::OP_SCL_ADD;
        state_next = S_SSUM;
      end
      S_SSUM: begin
        cmd.op = qap_pkg::OP_SCL_SUM;
        i_next = i + 2'd1;
        state_next = (i == 2'd3) ? S_SQMUL : S_TMUL;
      end
      S_SQMUL: begin
        cmd.op     = qap_pkg::OP_SQ_MUL;
        state_next = S_SQACC;
      end
      S_SQACC: begin
        cmd.op     = qap_pkg::OP_SQ_ACC;
        i_next     = i + 2'd1;
        state_next = (i == 2'd3) ? S_CHK : S_SQMUL;
      end
      S_CHK: begin
        it_next = '0;
        if (stat.norm_zero) begin
          cmd.op     = qap_pkg::OP_IDENT;
          state_next = S_OUT;
        end else begin
          cmd.op     = qap_pkg::OP_SQRT_INIT;
          state_next = S_SQS;
        end
      end
      S_SQS: begin
        cmd.op  = qap_pkg::OP_SQRT_STEP;
        it_next = it + 5'd1;
        if (it == 5'd31) begin
          i_next     = '0;
          state_next = S_DVI;
        end
      end
      S_DVI: begin
        cmd.op     = qap_pkg::OP_DIV_INIT;
        it_next    = '0;
        state_next = S_DVS;
      end
      S_DVS: begin
        cmd.op  = qap_pkg::OP_DIV_STEP;
        it_next = it + 5'd1;
        if (it == 5'd30) begin
          state_next = S_DVW;
        end
      end
      S_DVW: begin
        cmd.op     = qap_pkg::OP_DIV_WRITE;
        i_next     = i + 2'd1;
        state_next = (i == 2'd3) ? S_OUT : S_DVI;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op     = qap_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      i     <= '0;
      it    <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      i     <= i_next;
      it    <= it_next;
    end
  end

endmodule

// File: sv/quaternion_attitude_propagator.sv
// ----------------------------------------------------------------------------
// quaternion_attitude_propagator
// Euler-integrated quaternion kinematics with renormalization, fixed point.
// ----------------------------------------------------------------------------
// Sequence: a load beat skips the product terms and dt scaling that a propagate
//   beat runs; root and divisions are skipped when the identity fallback fires.
// Throughput: one beat at a time; set by the 32-step square root and four
//   31-step restoring divisions that share one subtractor each.
// Reset: synchronous; attitude returns to identity, time_step to 0.01 s,
//   the response channel empties.
module quaternion_attitude_propagator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  qap_req_if.sink     req,
  qap_rsp_if.source   rsp
);

  qap_pkg::cmd_t  cmd;
  qap_pkg::stat_t stat;
  logic           in_fire;

  // A request beat is taken only while the sequencer is idle; the response
  // register keeps the previous beat until the sink takes it.
  assign in_fire = req.valid && req.ready;

  // Sequencer: walks product terms, dt scaling, sum of squares,
  // root and per-component division.
  qap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .command  (req.command),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Datapath: holds attitude and time step, the output register,
  // and all arithmetic units.
  qap_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .load_w    (req.load_w),
    .load_x    (req.load_x),
    .load_y    (req.load_y),
    .load_z    (req.load_z),
    .rate_x    (req.rate_x),
    .rate_y    (req.rate_y),
    .rate_z    (req.rate_z),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .att_w     (rsp.att_w),
    .att_x     (rsp.att_x),
    .att_y     (rsp.att_y),
    .att_z     (rsp.att_z),
    .fallback  (rsp.identity_fallback)
  );

endmodule

// File: sv/qap_checker.sv
// ----------------------------------------------------------------------------
// qap_checker
// Port-level checks on the attitude propagator, bound to the top level.
// ----------------------------------------------------------------------------
`include "quaternion_attitude_propagator_assert.svh"

module qap_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic signed [31:0] att_w,
  input logic signed [31:0] att_x,
  input logic signed [31:0] att_y,
  input logic signed [31:0] att_z,
  input logic               identity_fallback
);

  // one beat in flight: ready drops right after a request beat
  `QAP_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)

  // fallback beats carry the identity quaternion
  `QAP_ASSERT_NOW(a_fallback_identity, clk, rst, rsp_valid && identity_fallback, att_w == 32'sh4000_0000 && att_x == 32'sd0 && att_y == 32'sd0 && att_z == 32'sd0)

  // hold a stalled response beat
  `QAP_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `QAP_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(att_w) && $stable(identity_fallback))

endmodule

bind quaternion_attitude_propagator qap_checker u_qap_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .att_w             (rsp.att_w),
  .att_x             (rsp.att_x),
  .att_y             (rsp.att_y),
  .att_z             (rsp.att_z),
  .identity_fallback (rsp.identity_fallback)
);

// File: tb/qap_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench channel helpers
// Holds the beat record types shared by the attitude propagator testbench.
// ----------------------------------------------------------------------------
package qap_tb_pkg;

  localparam logic CMD_LOAD      = 1'b0;
  localparam logic CMD_PROPAGATE = 1'b1;

  typedef struct {
    logic        command;
    logic [31:0] lw, lx, ly, lz;
    logic [31:0] rx, ry, rz;
  } req_beat_t;

  typedef struct {
    logic [31:0] w, x, y, z;
    logic        fallback;
  } att_beat_t;

endpackage

// File: tb/tb_quaternion_attitude_propagator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attitude propagator testbench
// Drives load and propagate beats with bursty flow control and receiver
// stalls, predicts each attitude response in fixed point and compares every
// field against the response beats in order.
// ----------------------------------------------------------------------------
module tb_quaternion_attitude_propagator;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  qap_req_if req ();
  qap_rsp_if rsp ();

  quaternion_attitude_propagator u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req.sink),
    .rsp      (rsp.source)
  );

  // Predictor state: attitude quaternion and integration step.
  logic signed [63:0] att_q [4];
  logic [31:0]        step_q032;

  qap_tb_pkg::att_beat_t att_expected [$];
  int unsigned mismatch_count;
  int unsigned hold_off_cycles;   // long receiver hold-off request
  bit          stall_enable;      // random receiver stalls on/off

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Fixed-point helpers for the predictor
  // --------------------------------------------------------------------------
  function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] n_in);
    logic [63:0] n, res, bitv;
    n = n_in;
    res = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Scale a doubled rate term by the time step: floor(r * dt / 2^33).
  function automatic logic signed [63:0] apply_step(input logic signed [63:0] r);
    logic signed [63:0] hi, lo;
    hi = {48'd0, step_q032[31:16]};
    lo = {48'd0, step_q032[15:0]};
    return (r * hi + ((r * lo) >>> 16)) >>> 17;
  endfunction

  // Renormalize c into the attitude; return the fallback flag.
  function automatic logic renormalize(input logic signed [63:0] c [4]);
    logic [63:0] sum_sq, mag, sq, root, quot;
    sum_sq = '0;
    for (int i = 0; i < 4; i++) begin
      mag = c[i] < 0 ? -c[i] : c[i];
      sq = mag * mag;
      sum_sq = (sum_sq > ~sq) ? '1 : sum_sq + sq;
    end
    if (sum_sq == 0) begin
      att_q[0] = 64'sd1 << 30;
      att_q[1] = 0;
      att_q[2] = 0;
      att_q[3] = 0;
      return 1'b1;
    end
    root = root_floor(sum_sq);
    for (int i = 0; i < 4; i++) begin
      mag = c[i] < 0 ? -c[i] : c[i];
      quot = (mag << 30) / root;
      att_q[i] = clamp_q(c[i] < 0 ? -$signed(quot) : $signed(quot));
    end
    return 1'b0;
  endfunction

  function automatic qap_tb_pkg::att_beat_t predict_attitude(
    input qap_tb_pkg::req_beat_t b);
    logic signed [63:0] c [4];
    logic signed [63:0] r [4];
    logic signed [63:0] w, x, y, z, ox, oy, oz;
    qap_tb_pkg::att_beat_t e;
    if (b.command == qap_tb_pkg::CMD_LOAD) begin
      c[0] = $signed(b.lw);
      c[1] = $signed(b.lx);
      c[2] = $signed(b.ly);
      c[3] = $signed(b.lz);
    end else begin
      w = att_q[0]; x = att_q[1]; y = att_q[2]; z = att_q[3];
      ox = $signed(b.rx); oy = $signed(b.ry); oz = $signed(b.rz);
      r[0] = -(((x * ox) >>> 24) + ((y * oy) >>> 24) + ((z * oz) >>> 24));
      r[1] = ((w * ox) >>> 24) + ((y * oz) >>> 24) - ((z * oy) >>> 24);
      r[2] = ((w * oy) >>> 24) - ((x * oz) >>> 24) + ((z * ox) >>> 24);
      r[3] = ((w * oz) >>> 24) + ((x * oy) >>> 24) - ((y * ox) >>> 24);
      for (int i = 0; i < 4; i++) c[i] = clamp_q(att_q[i] + apply_step(r[i]));
    end
    e.fallback = renormalize(c);
    e.w = att_q[0][31:0];
    e.x = att_q[1][31:0];
    e.y = att_q[2][31:0];
    e.z = att_q[3][31:0];
    return e;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one beat, with optional random gap before it (bursty traffic)
  // --------------------------------------------------------------------------
  int burst_left;

  task automatic send_beat(input qap_tb_pkg::req_beat_t b);
    // advance past the edge where the previous beat dropped valid
    @(negedge clk);
    if (burst_left == 0) begin
      // end of burst: hold valid low for a random gap, then start a new burst
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) burst_left = 0;   // some back-to-back gaps
      if (burst_left == 0) burst_left = 1;
    end
    burst_left--;
    req.valid   <= 1'b1;
    req.command <= b.command;
    req.load_w  <= b.lw;
    req.load_x  <= b.lx;
    req.load_y  <= b.ly;
    req.load_z  <= b.lz;
    req.rate_x  <= b.rx;
    req.rate_y  <= b.ry;
    req.rate_z  <= b.rz;
    // hold until accepted
    do @(posedge clk); while (!req.ready);
    att_expected.push_back(predict_attitude(b));
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  function automatic qap_tb_pkg::req_beat_t load_beat(input logic [31:0] w, x, y, z);
    qap_tb_pkg::req_beat_t b;
    b.command = qap_tb_pkg::CMD_LOAD;
    b.lw = w; b.lx = x; b.ly = y; b.lz = z;
    b.rx = $urandom; b.ry = $urandom; b.rz = $urandom;
    return b;
  endfunction

  function automatic qap_tb_pkg::req_beat_t prop_beat(input logic [31:0] ox, oy, oz);
    qap_tb_pkg::req_beat_t b;
    b.command = qap_tb_pkg::CMD_PROPAGATE;
    b.lw = $urandom; b.lx = $urandom; b.ly = $urandom; b.lz = $urandom;
    b.rx = ox; b.ry = oy; b.rz = oz;
    return b;
  endfunction

  // Random rate: mostly modest rates, sometimes any 32-bit value.
  function automatic logic [31:0] rand_rate();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
  endfunction

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return $urandom;
      2:       return $urandom_range(0, 3) - 1;
      default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endcase
  endfunction

  // Wait for every response, then let the block settle before a config write.
  task automatic drain();
    while (att_expected.size() != 0) @(posedge clk);
    repeat (240) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_step(input logic [31:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    step_q032 = v;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall pattern, plus long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        rsp.ready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end else if (stall_enable) begin
        rsp.ready <= ($urandom_range(0, 9) > 2);
      end else begin
        rsp.ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  // Checker: compare every response beat with the oldest prediction.
  initial begin
    qap_tb_pkg::att_beat_t e;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (att_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected response beat: w=%h x=%h y=%h z=%h fb=%b",
                     rsp.att_w, rsp.att_x, rsp.att_y, rsp.att_z,
                     rsp.identity_fallback);
        end else begin
          e = att_expected.pop_front();
          if (rsp.att_w !== e.w || rsp.att_x !== e.x || rsp.att_y !== e.y ||
              rsp.att_z !== e.z || rsp.identity_fallback !== e.fallback) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("attitude mismatch: exp w=%h x=%h y=%h z=%h fb=%b, got w=%h x=%h y=%h z=%h fb=%b",
                       e.w, e.x, e.y, e.z, e.fallback, rsp.att_w, rsp.att_x,
                       rsp.att_y, rsp.att_z, rsp.identity_fallback);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Loads at the field extremes, the all-zero fallback and sign mixes.
  task automatic test_load_extremes();
    send_beat(load_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_beat(load_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_beat(load_beat(32'h8000_0000, 32'h0, 32'h0, 32'h0));
    send_beat(load_beat(32'h0, 32'h0, 32'h0, 32'h0));        // zero norm
    send_beat(load_beat(32'h0, 32'h0, 32'h0, 32'h1));        // smallest norm
    send_beat(load_beat(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1));
    send_beat(load_beat(32'h4000_0000, 32'h0, 32'h0, 32'h0));
  endtask

  // Propagate with extreme rates from several attitudes.
  task automatic test_propagate_extremes();
    send_beat(prop_beat(32'h0, 32'h0, 32'h0));
    send_beat(prop_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_beat(prop_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_beat(load_beat(32'h2000_0000, 32'hE000_0000, 32'h2000_0000, 32'hE000_0000));
    send_beat(prop_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h0100_0000));
    send_beat(prop_beat(32'h0100_0000, 32'h0, 32'hFF00_0000));
  endtask

  // Steps at the extremes; max step with max rate drives saturation.
  task automatic test_step_extremes();
    write_step(32'hFFFF_FFFF);
    send_beat(load_beat(32'h4000_0000, 32'h0, 32'h0, 32'h0));
    send_beat(prop_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_beat(prop_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    write_step(32'h0);
    send_beat(prop_beat(32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000));
    write_step(32'h0001_0000);
    send_beat(prop_beat(32'h0300_0000, 32'hFD00_0000, 32'h0080_0000));
  endtask

  // Random traffic across a few steps; mostly propagate chains after a load.
  task automatic test_random_traffic(input int n);
    logic [31:0] steps [4];
    steps = '{32'd42949673, 32'd429496730, $urandom, 32'd4294967};
    for (int s = 0; s < 4; s++) begin
      write_step(steps[s]);
      stall_enable = (s != 1);   // one phase with a free-running receiver
      for (int i = 0; i < n / 4; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(load_beat(rand_part(), rand_part(), rand_part(), rand_part()));
        else
          send_beat(prop_beat(rand_rate(), rand_rate(), rand_rate()));
      end
    end
  endtask

  // Long receiver hold-off while the sender keeps offering beats.
  task automatic test_back_pressure();
    hold_off_cycles = 2000;
    burst_left = 20;
    for (int i = 0; i < 8; i++)
      send_beat(prop_beat(rand_rate(), rand_rate(), rand_rate()));
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req.valid      = 1'b0;
    req.command    = qap_tb_pkg::CMD_LOAD;
    req.load_w     = '0;
    req.load_x     = '0;
    req.load_y     = '0;
    req.load_z     = '0;
    req.rate_x     = '0;
    req.rate_y     = '0;
    req.rate_z     = '0;
    mismatch_count = 0;
    hold_off_cycles = 0;
    stall_enable   = 1'b1;
    burst_left     = 0;
    att_q[0] = 64'sd1 << 30;
    att_q[1] = 0;
    att_q[2] = 0;
    att_q[3] = 0;
    step_q032 = 32'd42949673;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_propagate_extremes();
    test_load_extremes();
    test_step_extremes();
    test_back_pressure();
    test_random_traffic(480);

    drain();
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/qap_pkg.sv
sv/qap_if.sv
sv/qap_datapath.sv
sv/qap_ctrl.sv
sv/quaternion_attitude_propagator.sv
sv/qap_checker.sv
tb/qap_tb_if.sv
tb/tb_quaternion_attitude_propagator.sv
